/* rtl/cubemap_face_texel_address_unit_defines.svh */
// Assertion macros used by the cube-map face/texel address top level.
// No dependencies; include by bare file name inside a module body.
`ifndef CUBEMAP_FACE_TEXEL_ADDRESS_UNIT_DEFINES_SVH
`define CUBEMAP_FACE_TEXEL_ADDRESS_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define CFTA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cfta assertion failed");

// Next-cycle implication, disabled during reset.
`define CFTA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cfta assertion failed");

`endif

/* rtl/cfta_pkg.sv */
// Package for the cube-map face/texel address unit: widths, codes, stage types,
// the divider step function and the face-size clamp. No dependencies.
package cfta_pkg;

    localparam int COORD_BITS     = 16;
    localparam int FRAC_BITS      = 16;
    localparam int MAX_FACE_DIM   = 4096;

    localparam int CFG_W          = 13;
    localparam int CFG_IDX_W      = 1;
    localparam int TEXEL_W        = 12;
    localparam int FACE_W         = 3;

    localparam int MAG_W          = COORD_BITS;       // |component| up to 2^(C-1)
    localparam int SC_W           = COORD_BITS + 1;   // negated component fits
    localparam int DIV_W          = COORD_BITS + 1;   // 2*ma and partial remainder
    localparam int DIM_W          = $clog2(MAX_FACE_DIM + 1);
    localparam int PROD_W         = FRAC_BITS + DIM_W;
    localparam int BITS_PER_STAGE = 2;
    localparam int DIV_STAGES     = (FRAC_BITS + BITS_PER_STAGE - 1) / BITS_PER_STAGE;

    typedef enum logic [FACE_W-1:0] {
        FACE_POS_X = 3'd0,
        FACE_NEG_X = 3'd1,
        FACE_POS_Y = 3'd2,
        FACE_NEG_Y = 3'd3,
        FACE_POS_Z = 3'd4,
        FACE_NEG_Z = 3'd5
    } face_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FACE_WIDTH  = 1'b0,
        REG_FACE_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic                    zero;
        face_t                   face;
        logic signed [SC_W-1:0]  sc;
        logic signed [SC_W-1:0]  tc;
        logic [MAG_W-1:0]        ma;
    } sel_t;

    typedef struct packed {
        logic                    zero;
        face_t                   face;
        logic [DIV_W-1:0]        den;
        logic [DIV_W-1:0]        ru;
        logic [DIV_W-1:0]        rv;
        logic [FRAC_BITS-1:0]    qu;
        logic [FRAC_BITS-1:0]    qv;
    } div_t;

    typedef struct packed {
        logic [DIV_W-1:0]        rem;
        logic [FRAC_BITS-1:0]    quo;
    } step_t;

    // Restoring division, BITS_PER_STAGE quotient bits; bits past FRAC_BITS skipped.
    function automatic step_t div_step(input logic [DIV_W-1:0] den,
                                       input logic [DIV_W-1:0] rem_in,
                                       input logic [FRAC_BITS-1:0] quo_in,
                                       input int first);
        step_t          res;
        logic [DIV_W:0] r2;
        res.rem = rem_in;
        res.quo = quo_in;
        for (int k = 0; k < BITS_PER_STAGE; k++) begin
            if (first + k < FRAC_BITS) begin
                r2 = {res.rem, 1'b0};
                if (r2 >= {1'b0, den}) begin
                    r2      = r2 - {1'b0, den};
                    res.quo = {res.quo[FRAC_BITS-2:0], 1'b1};
                end
                else begin
                    res.quo = {res.quo[FRAC_BITS-2:0], 1'b0};
                end
                res.rem = r2[DIV_W-1:0];
            end
        end
        return res;
    endfunction

    // Zero reads as one, oversize saturates.
    function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_W-1:0] r);
        logic [DIM_W-1:0] d;
        if (r == '0)
            d = DIM_W'(1);
        else if (32'(r) > MAX_FACE_DIM)
            d = DIM_W'(MAX_FACE_DIM);
        else
            d = DIM_W'(r);
        return d;
    endfunction

endpackage

/* rtl/cfta_face_sel.sv */
// Major-axis face pick and sc/tc/ma selection for one direction vector.
// Depends on cfta_pkg.
module cfta_face_sel (
    input  logic signed [cfta_pkg::COORD_BITS-1:0] x,
    input  logic signed [cfta_pkg::COORD_BITS-1:0] y,
    input  logic signed [cfta_pkg::COORD_BITS-1:0] z,
    output cfta_pkg::sel_t                         sel
);
    import cfta_pkg::*;

    logic signed [SC_W-1:0] xe, ye, ze;
    logic signed [SC_W-1:0] xa, ya, za;
    logic [MAG_W-1:0]       ax, ay, az;
    logic                   xpos, ypos, zpos;

    assign xe = SC_W'(x);
    assign ye = SC_W'(y);
    assign ze = SC_W'(z);
    assign xa = xe[SC_W-1] ? -xe : xe;
    assign ya = ye[SC_W-1] ? -ye : ye;
    assign za = ze[SC_W-1] ? -ze : ze;
    assign ax = xa[MAG_W-1:0];
    assign ay = ya[MAG_W-1:0];
    assign az = za[MAG_W-1:0];
    assign xpos = !x[COORD_BITS-1] && (x != '0);
    assign ypos = !y[COORD_BITS-1] && (y != '0);
    assign zpos = !z[COORD_BITS-1] && (z != '0);

    always_comb
    begin
        sel.zero = (x == '0) && (y == '0) && (z == '0);
        if (ax > ay && ax > az) begin
            sel.ma = ax;
            sel.tc = ye;
            if (xpos) begin
                sel.face = FACE_POS_X;
                sel.sc   = ze;
            end
            else begin
                sel.face = FACE_NEG_X;
                sel.sc   = -ze;
            end
        end
        else if (ay > az) begin
            sel.ma = ay;
            sel.sc = xe;
            if (ypos) begin
                sel.face = FACE_POS_Y;
                sel.tc   = ze;
            end
            else begin
                sel.face = FACE_NEG_Y;
                sel.tc   = -ze;
            end
        end
        else begin
            sel.ma = az;
            sel.tc = ye;
            if (zpos) begin
                sel.face = FACE_POS_Z;
                sel.sc   = -xe;
            end
            else begin
                sel.face = FACE_NEG_Z;
                sel.sc   = xe;
            end
        end
    end

endmodule

/* rtl/cubemap_face_texel_address_unit.sv */
// Top level of the cube-map face/texel address unit: pipeline, config regs.
// Depends on cfta_pkg, cfta_face_sel and cubemap_face_texel_address_unit_defines.svh.
//
// Usage:
//   Input channel: dir_x/dir_y/dir_z with in_valid/in_stall. A transaction
//   completes on a clock edge with in_valid high and in_stall low.
//   Output channel: face, u_frac, v_frac, texel_x, texel_y, zero_vector with
//   out_valid/out_stall, same rule.
//   Config: cfg_wr_en writes cfg_wdata into face_width (index 0) or
//   face_height (index 1). Write only while the pipeline is empty.
//   Throughput: one transaction per clock while out_stall is low. Stages, in
//   order: one face-select stage, one divider setup stage, the divide
//   stages with two quotient bits per stage for u and v in parallel, then
//   one 16x13 multiply stage that is also the output reg.
//   Reset: all stages empty, both face sizes return to 512.
//   Stall: each stage holds while the next one is full and stalled; bubbles
//   collapse, so in_stall rises only when every stage holds a transaction.
module cubemap_face_texel_address_unit (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_wr_en,
    input  logic [cfta_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [cfta_pkg::CFG_W-1:0]             cfg_wdata,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic signed [cfta_pkg::COORD_BITS-1:0] dir_x,
    input  logic signed [cfta_pkg::COORD_BITS-1:0] dir_y,
    input  logic signed [cfta_pkg::COORD_BITS-1:0] dir_z,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic [cfta_pkg::FACE_W-1:0]            face,
    output logic [cfta_pkg::FRAC_BITS-1:0]         u_frac,
    output logic [cfta_pkg::FRAC_BITS-1:0]         v_frac,
    output logic [cfta_pkg::TEXEL_W-1:0]           texel_x,
    output logic [cfta_pkg::TEXEL_W-1:0]           texel_y,
    output logic                                   zero_vector
);
    import cfta_pkg::*;
    `include "cubemap_face_texel_address_unit_defines.svh"

    // Stage map: 0 select, 1 divider setup, 2..DIV_STAGES+1 divide, last output.
    localparam int NST = DIV_STAGES + 3;

    typedef struct packed {
        logic                 zero;
        face_t                face;
        logic [FRAC_BITS-1:0] u;
        logic [FRAC_BITS-1:0] v;
        logic [PROD_W-1:0]    px;
        logic [PROD_W-1:0]    py;
    } out_t;

    logic [CFG_W-1:0] face_width_reg, face_height_reg;
    logic [DIM_W-1:0] eff_w, eff_h;

    logic [NST-1:0]   vld_reg;
    logic [NST-1:0]   rdy;

    sel_t             sel_next, sel_reg;
    div_t             div_reg [DIV_STAGES+1];
    div_t             init_next;
    out_t             out_next, out_reg;

    logic signed [SC_W:0] nu, nv;

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            face_width_reg  <= CFG_W'(512);
            face_height_reg <= CFG_W'(512);
        end
        else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_FACE_WIDTH:  face_width_reg  <= cfg_wdata;
                REG_FACE_HEIGHT: face_height_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign eff_w = eff_dim(face_width_reg);
    assign eff_h = eff_dim(face_height_reg);

    // ---------------- flow control ----------------
    // A stage takes new data when empty or when its contents move on.
    always_comb
    begin
        rdy[NST-1] = !vld_reg[NST-1] || !out_stall;
        for (int i = NST - 2; i >= 0; i--)
            rdy[i] = !vld_reg[i] || rdy[i+1];
    end

    assign in_stall = !rdy[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            vld_reg <= '0;
        end
        else begin
            if (rdy[0])
                vld_reg[0] <= in_valid;
            for (int i = 1; i < NST; i++)
                if (rdy[i])
                    vld_reg[i] <= vld_reg[i-1];
        end
    end

    // ---------------- stage 0: face select ----------------
    cfta_face_sel u_face_sel (
        .x   (dir_x),
        .y   (dir_y),
        .z   (dir_z),
        .sel (sel_next)
    );

    always_ff @(posedge clk)
    begin
        if (rdy[0])
            sel_reg <= sel_next;
    end

    // ---------------- stage 1: divider setup ----------------
    // n = s + ma in [0, 2ma]; n == 2ma is the 1.0 case, which wraps to 0.
    assign nu = (SC_W+1)'(sel_reg.sc) + (SC_W+1)'(sel_reg.ma);
    assign nv = (SC_W+1)'(sel_reg.tc) + (SC_W+1)'(sel_reg.ma);

    always_comb
    begin
        init_next.zero = sel_reg.zero;
        init_next.face = sel_reg.face;
        init_next.den  = {sel_reg.ma, 1'b0};
        init_next.ru   = (nu[DIV_W-1:0] == init_next.den) ? '0 : nu[DIV_W-1:0];
        init_next.rv   = (nv[DIV_W-1:0] == init_next.den) ? '0 : nv[DIV_W-1:0];
        init_next.qu   = '0;
        init_next.qv   = '0;
    end

    always_ff @(posedge clk)
    begin
        if (rdy[1])
            div_reg[0] <= init_next;
    end

    // ---------------- divide stages ----------------
    for (genvar g = 1; g <= DIV_STAGES; g++) begin : g_div
        div_t  nxt;
        step_t su, sv;

        assign su = div_step(div_reg[g-1].den, div_reg[g-1].ru, div_reg[g-1].qu,
                             (g - 1) * BITS_PER_STAGE);
        assign sv = div_step(div_reg[g-1].den, div_reg[g-1].rv, div_reg[g-1].qv,
                             (g - 1) * BITS_PER_STAGE);

        always_comb
        begin
            nxt      = div_reg[g-1];
            nxt.ru   = su.rem;
            nxt.qu   = su.quo;
            nxt.rv   = sv.rem;
            nxt.qv   = sv.quo;
        end

        always_ff @(posedge clk)
        begin
            if (rdy[g+1])
                div_reg[g] <= nxt;
        end
    end

    // ---------------- output stage: scale to texels ----------------
    always_comb
    begin
        out_next.zero = div_reg[DIV_STAGES].zero;
        out_next.face = div_reg[DIV_STAGES].zero ? FACE_POS_X : div_reg[DIV_STAGES].face;
        out_next.u    = div_reg[DIV_STAGES].zero ? '0 : div_reg[DIV_STAGES].qu;
        out_next.v    = div_reg[DIV_STAGES].zero ? '0 : div_reg[DIV_STAGES].qv;
        out_next.px   = PROD_W'(out_next.u) * PROD_W'(eff_w);
        out_next.py   = PROD_W'(out_next.v) * PROD_W'(eff_h);
    end

    always_ff @(posedge clk)
    begin
        if (rdy[NST-1])
            out_reg <= out_next;
    end

    assign out_valid   = vld_reg[NST-1];
    assign face        = out_reg.face;
    assign u_frac      = out_reg.u;
    assign v_frac      = out_reg.v;
    assign texel_x     = out_reg.px[FRAC_BITS +: TEXEL_W];
    assign texel_y     = out_reg.py[FRAC_BITS +: TEXEL_W];
    assign zero_vector = out_reg.zero;

    // ---------------- assertions ----------------
    `CFTA_ASSERT_IMPL(a_zero_clears, clk, rst_n, out_valid && zero_vector,
                      face == FACE_POS_X && u_frac == '0 && v_frac == '0
                      && texel_x == '0 && texel_y == '0)
    `CFTA_ASSERT_IMPL(a_face_range, clk, rst_n, out_valid, face <= FACE_NEG_Z)
    `CFTA_ASSERT_IMPL(a_texel_x_range, clk, rst_n, out_valid, DIM_W'(texel_x) < eff_w)
    `CFTA_ASSERT_IMPL(a_stall_only_full, clk, rst_n, in_stall, &vld_reg)
    `CFTA_ASSERT_NEXT(a_held_on_stall, clk, rst_n, vld_reg[NST-2] && !rdy[NST-1], vld_reg[NST-2])

endmodule

/* tb/sv/cfta_texel_scoreboard.sv */
`timescale 1ns / 100ps
// Scoreboard class for the cube-map face/texel address unit testbench.
// Depends on cfta_pkg; holds the face/uv/texel predictor and expected queue.
class cfta_texel_scoreboard;

    typedef struct {
        logic [2:0]  face;
        logic [15:0] u;
        logic [15:0] v;
        logic [11:0] tx;
        logic [11:0] ty;
        logic        zero;
    } texel_addr_t;

    texel_addr_t pending[$];
    logic [12:0] width_reg  = 13'd512;
    logic [12:0] height_reg = 13'd512;
    int          errors     = 0;

    function automatic longint face_dim(logic [12:0] r);
        if (r == 0)
            return 1;
        if (r > cfta_pkg::MAX_FACE_DIM)
            return cfta_pkg::MAX_FACE_DIM;
        return r;
    endfunction

    function automatic longint uv_frac(longint s, longint m);
        longint q;
        q = ((s + m) << 16) / (2 * m);
        if (q >= 65536)
            q -= 65536;
        return q;
    endfunction

    function void set_reg(cfta_pkg::cfg_reg_t idx, logic [12:0] val);
        if (idx == cfta_pkg::REG_FACE_WIDTH)
            width_reg = val;
        else
            height_reg = val;
    endfunction

    function void note_direction(logic signed [15:0] dx, logic signed [15:0] dy,
                                 logic signed [15:0] dz);
        texel_addr_t e;
        longint x, y, z, ax, ay, az, ma, sc, tc, u, v;
        x = dx; y = dy; z = dz;
        ax = x < 0 ? -x : x;
        ay = y < 0 ? -y : y;
        az = z < 0 ? -z : z;
        e = '{default: 0};
        if (x == 0 && y == 0 && z == 0) begin
            e.zero = 1'b1;
            pending.push_back(e);
            return;
        end
        if (ax > ay && ax > az) begin
            ma = ax;
            if (x > 0) begin e.face = cfta_pkg::FACE_POS_X; sc = z; tc = y; end
            else begin e.face = cfta_pkg::FACE_NEG_X; sc = -z; tc = y; end
        end
        else if (ay > az) begin
            ma = ay;
            if (y > 0) begin e.face = cfta_pkg::FACE_POS_Y; sc = x; tc = z; end
            else begin e.face = cfta_pkg::FACE_NEG_Y; sc = x; tc = -z; end
        end
        else begin
            ma = az;
            if (z > 0) begin e.face = cfta_pkg::FACE_POS_Z; sc = -x; tc = y; end
            else begin e.face = cfta_pkg::FACE_NEG_Z; sc = x; tc = y; end
        end
        u = uv_frac(sc, ma);
        v = uv_frac(tc, ma);
        e.u  = u[15:0];
        e.v  = v[15:0];
        e.tx = 12'((u * face_dim(width_reg)) >> 16);
        e.ty = 12'((v * face_dim(height_reg)) >> 16);
        pending.push_back(e);
    endfunction

    function void check_result(logic [2:0] f, logic [15:0] u, logic [15:0] v,
                               logic [11:0] tx, logic [11:0] ty, logic zv);
        texel_addr_t e;
        if (pending.size() == 0) begin
            $error("unexpected result transaction");
            errors++;
            return;
        end
        e = pending.pop_front();
        if (f != e.face) begin $error("face exp %0d got %0d", e.face, f); errors++; end
        if (u != e.u) begin $error("u_frac exp %0d got %0d", e.u, u); errors++; end
        if (v != e.v) begin $error("v_frac exp %0d got %0d", e.v, v); errors++; end
        if (tx != e.tx) begin $error("texel_x exp %0d got %0d", e.tx, tx); errors++; end
        if (ty != e.ty) begin $error("texel_y exp %0d got %0d", e.ty, ty); errors++; end
        if (zv != e.zero) begin
            $error("zero_vector exp %0d got %0d", e.zero, zv);
            errors++;
        end
    endfunction

endclass

/* tb/sv/tb.sv */
`timescale 1ns / 100ps
// Top-level testbench for cubemap_face_texel_address_unit.
// Depends on cfta_pkg, the DUT and cfta_texel_scoreboard.
module tb;
    import cfta_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic signed [15:0] dir_x = '0, dir_y = '0, dir_z = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  face;
    logic [15:0] u_frac, v_frac;
    logic [11:0] texel_x, texel_y;
    logic        zero_vector;

    // idle percentages for sender and receiver, changed per phase
    int send_idle = 0;
    int recv_idle = 0;
    longint cycle_count = 0;
    localparam longint CYCLE_LIMIT = 400000;

    cfta_texel_scoreboard addr_sb = new();

    cubemap_face_texel_address_unit DUT (.*);

    always #5 clk = ~clk;

    // timeout watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // receiver: random stall, check every accepted result transaction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            addr_sb.check_result(face, u_frac, v_frac, texel_x, texel_y, zero_vector);
        out_stall <= ($urandom_range(99) < recv_idle);
    end

    // config write; only called with the pipeline drained
    task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        addr_sb.set_reg(idx, val);
        @(posedge clk);
    endtask

    // one input transaction with optional leading idle cycles;
    // in_valid stays high afterwards so back-to-back sends leave no gap
    task automatic send_dir(logic signed [15:0] x, logic signed [15:0] y,
                            logic signed [15:0] z);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        dir_x <= x;
        dir_y <= y;
        dir_z <= z;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        addr_sb.note_direction(x, y, z);
    endtask

    // stop sending, wait for every expected result, then idle further so the pipeline is empty
    task automatic drain();
        in_valid <= 1'b0;
        while (addr_sb.pending.size() != 0)
            @(posedge clk);
        repeat (DIV_STAGES + 6) @(posedge clk);
    endtask

    // random direction: mostly wide, some tiny, some edge/tie shaped
    task automatic send_random();
        logic signed [15:0] x, y, z;
        int kind;
        kind = $urandom_range(9);
        x = 16'($urandom); y = 16'($urandom); z = 16'($urandom);
        if (kind == 0)
        begin
            x = 16'($signed($urandom_range(6)) - 3);
            y = 16'($signed($urandom_range(6)) - 3);
            z = 16'($signed($urandom_range(6)) - 3);
        end
        else if (kind == 1)
            y = ($urandom_range(1)) ? x : -x;   // tie or exact edge
        else if (kind == 2)
            z = ($urandom_range(1)) ? y : -y;
        else if (kind == 3)
            x = 16'sh8000;
        send_dir(x, y, z);
    endtask

    logic [12:0] dims [6] = '{13'd1, 13'd4096, 13'd8191, 13'd0, 13'd640, 13'd4097};

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, every face, ties, exact edges, zero vector
        send_dir(0, 0, 0);
        send_dir(100, 5, -7);
        send_dir(-100, 5, -7);
        send_dir(3, 100, 7);
        send_dir(3, -100, 7);
        send_dir(3, 7, 100);
        send_dir(3, 7, -100);
        send_dir(50, 50, 10);
        send_dir(10, 50, 50);
        send_dir(50, 10, 50);
        send_dir(50, 50, 50);
        send_dir(100, 100, -100);
        send_dir(16'sh8000, 16'sh8000, 16'sh8000);
        send_dir(16'sh8000, 16'sh7fff, 16'sh7fff);
        send_dir(16'sh7fff, 16'sh7fff, 16'sh8000);
        send_dir(16'sh7fff, 0, 0);
        send_dir(-1, 0, 0);
        send_dir(0, 0, 1);
        send_dir(16'shffff, 16'shffff, 16'shffff);
        drain();

        // random phases across face sizes and idle mixes
        for (int ph = 0; ph < 6; ph++)
        begin
            write_reg(REG_FACE_WIDTH, dims[ph]);
            write_reg(REG_FACE_HEIGHT, dims[(ph + 2) % 6]);
            case (ph % 4)
                0: begin send_idle = 0;  recv_idle = 0;  end
                1: begin send_idle = 75; recv_idle = 0;  end
                2: begin send_idle = 0;  recv_idle = 75; end
                default: begin send_idle = 29; recv_idle = 29; end
            endcase
            for (int i = 0; i < 84; i++)
            begin
                send_random();
                // hold off until the pipeline empties once mid-phase
                if (i == 40)
                    drain();
            end
            drain();
        end
        recv_idle = 0;
        drain();

        if (addr_sb.errors == 0 && addr_sb.pending.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl
rtl/cfta_pkg.sv
rtl/cfta_face_sel.sv
rtl/cubemap_face_texel_address_unit.sv
tb/sv/cfta_texel_scoreboard.sv
tb/sv/tb.sv
